/* rtl/core/pol_pkg.sv */
// Package for the positional ordered list: request kinds, status codes,
// controller states and the command and status structs between modules.
// No dependencies.
`timescale 1ns / 1ps

package pol_pkg;

  // Fixed field widths of the stream payload.
  localparam int unsigned KindW   = 4;
  localparam int unsigned PosW    = 8;
  localparam int unsigned WordW   = 32;
  localparam int unsigned LenW    = 7;
  localparam int unsigned StatusW = 2;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 48;

  // Request kinds carried in the slave tuser field.
  typedef enum logic [KindW-1:0] {
    REQ_INS_FRONT = 4'd0,
    REQ_INS_BACK  = 4'd1,
    REQ_INS_AT    = 4'd2,
    REQ_DEL_FRONT = 4'd3,
    REQ_DEL_AT    = 4'd4,
    REQ_RD_FIRST  = 4'd5,
    REQ_RD_LAST   = 4'd6,
    REQ_RD_AT     = 4'd7,
    REQ_CLEAR     = 4'd8
  } req_kind_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // Operation class decoded from a request.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_DELETE,
    OP_READ,
    OP_CLEAR
  } op_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT_UP,
    S_PUT,
    S_SHIFT_DOWN,
    S_FINISH
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;    // capture the incoming request
    logic start;       // load the walk index
    logic rd_tgt;      // read the target entry
    logic shift_up;    // one step of opening a gap
    logic shift_down;  // one step of closing a gap
    logic put;         // write the new word at the target
    logic finish;      // update the length and load the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_e  op;
    logic ok;
    logic up_done;
    logic down_done;
    logic out_free;
  } sts_t;

endpackage

/* rtl/core/positional_ordered_list_top.sv */
// Top level of the positional ordered list: stream ports, controller and
// datapath. Depends on pol_pkg, pol_ctrl and pol_dpath.
`timescale 1ns / 1ps

// A bounded list of CAPACITY words kept in order and addressed by 1-based
// position. Each request on the slave stream (kind in tuser) gives exactly
// one result on the master stream: the word read, the new length and a
// status. One request is processed at a time. Reads, clears and rejected
// requests go from the decode state straight to the finish state. An insert
// opens a gap by a shift walk and then writes the new word; a delete closes
// the gap by a shift walk. The entries behind the position move one per
// cycle through the entry memory, which does one read and one write a cycle.
// The longest request is an insert at the front of a list that holds
// CAPACITY - 1 entries. The next request is accepted in the cycle after a
// result is loaded. A result is loaded even while the previous one is still
// being taken. While an older result still waits in the output register, a
// finished request stalls in its last cycle.
module positional_ordered_list_top import pol_pkg::*; #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned ENTRY_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // position [7:0], entry_in [39:8]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // req_type [3:0]
  input  logic [KindW-1:0]    s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // entry_out [31:0], list_length [38:32], status [40:39], zeros above
  output logic [OutDataW-1:0] m_axis_tdata
);

  cmd_t                cmd;
  sts_t                sts;
  logic [WordW-1:0]    out_word;
  logic [LenW-1:0]     out_len;
  logic [StatusW-1:0]  out_status;

  // Request sequencing.
  pol_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Storage, decode and result register.
  pol_dpath #(
    .CAPACITY    (CAPACITY),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_kind_i   (s_axis_tuser),
    .req_pos_i    (s_axis_tdata[PosW-1:0]),
    .req_word_i   (s_axis_tdata[PosW+WordW-1:PosW]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_word_o   (out_word),
    .out_len_o    (out_len),
    .out_status_o (out_status)
  );

  // Pack the result transaction.
  assign m_axis_tdata = OutDataW'({out_status, out_len, out_word});

endmodule

/* rtl/core/pol_ctrl.sv */
// Controller state machine of the positional ordered list.
// Depends on pol_pkg for the state enum and the command and status structs.
`timescale 1ns / 1ps

module pol_ctrl import pol_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts_i.ok) begin
          state_d = S_FINISH;
        end else begin
          case (sts_i.op)
            OP_INSERT: begin
              cmd_o.start = 1'b1;
              state_d     = S_SHIFT_UP;
            end
            OP_DELETE: begin
              cmd_o.start = 1'b1;
              state_d     = S_SHIFT_DOWN;
            end
            OP_READ: begin
              cmd_o.rd_tgt = 1'b1;
              state_d      = S_FINISH;
            end
            default: begin
              state_d = S_FINISH;
            end
          endcase
        end
      end
      S_SHIFT_UP: begin
        if (sts_i.up_done) begin
          state_d = S_PUT;
        end else begin
          cmd_o.shift_up = 1'b1;
        end
      end
      S_PUT: begin
        cmd_o.put = 1'b1;
        state_d   = S_FINISH;
      end
      S_SHIFT_DOWN: begin
        if (sts_i.down_done) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.shift_down = 1'b1;
        end
      end
      S_FINISH: begin
        // Hold here while the previous result has not been taken.
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/pol_dpath.sv */
// Datapath of the positional ordered list: request registers, decode, entry
// memory with its shift walk, length counter and result register.
// Depends on pol_pkg for types and field widths.
`timescale 1ns / 1ps

module pol_dpath import pol_pkg::*; #(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned ENTRY_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic [KindW-1:0]     req_kind_i,
  input  logic [PosW-1:0]      req_pos_i,
  input  logic [WordW-1:0]     req_word_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [WordW-1:0]     out_word_o,
  output logic [LenW-1:0]      out_len_o,
  output logic [StatusW-1:0]   out_status_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Request registers.
  logic [KindW-1:0] kind_q;
  logic [PosW-1:0]  pos_q;
  logic [WordW-1:0] word_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      kind_q <= req_kind_i;
      pos_q  <= req_pos_i;
      word_q <= req_word_i;
    end
  end

  // Length counter.
  logic [CW-1:0] count_q, count_d;

  // Request decode against the current length.
  logic [8:0] pos_x, cnt_x, tgt_x;
  op_e        op;
  status_e    st;
  logic       full, empty, bad_ins, bad_pos;

  assign pos_x   = 9'(pos_q);
  assign cnt_x   = 9'(count_q);
  assign full    = (count_q == CW'(CAPACITY));
  assign empty   = (count_q == '0);
  assign bad_ins = (pos_x == '0) || (pos_x > cnt_x + 9'd1);
  assign bad_pos = (pos_x == '0) || (pos_x > cnt_x);

  always_comb begin
    op    = OP_NONE;
    st    = ST_OK;
    tgt_x = '0;
    case (kind_q)
      REQ_INS_FRONT, REQ_INS_BACK: begin
        op    = OP_INSERT;
        tgt_x = (kind_q == REQ_INS_BACK) ? cnt_x : '0;
        if (full) st = ST_FULL;
      end
      REQ_INS_AT: begin
        op    = OP_INSERT;
        tgt_x = pos_x - 9'd1;
        if (full) st = ST_FULL;
        else if (bad_ins) st = ST_BADPOS;
      end
      REQ_DEL_FRONT: begin
        op = OP_DELETE;
        if (empty) st = ST_EMPTY;
      end
      REQ_DEL_AT: begin
        op    = OP_DELETE;
        tgt_x = pos_x - 9'd1;
        if (empty) st = ST_EMPTY;
        else if (bad_pos) st = ST_BADPOS;
      end
      REQ_RD_FIRST: begin
        op = OP_READ;
        if (empty) st = ST_EMPTY;
      end
      REQ_RD_LAST: begin
        op    = OP_READ;
        tgt_x = cnt_x - 9'd1;
        if (empty) st = ST_EMPTY;
      end
      REQ_RD_AT: begin
        op    = OP_READ;
        tgt_x = pos_x - 9'd1;
        if (empty) st = ST_EMPTY;
        else if (bad_pos) st = ST_BADPOS;
      end
      REQ_CLEAR: begin
        op = OP_CLEAR;
      end
      default: begin
        op = OP_NONE;
      end
    endcase
  end

  logic [AW-1:0] tgt;
  assign tgt = AW'(tgt_x);

  // Walk index and the pending write of a shift step.
  logic [AW-1:0] idx_q, wr_addr_q;
  logic          wr_pend_q;
  logic [8:0]    idx_x;

  assign idx_x = 9'(idx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      idx_q <= (op == OP_INSERT) ? AW'(count_q) : tgt;
    end else if (cmd_i.shift_up) begin
      idx_q <= idx_q - AW'(1);
    end else if (cmd_i.shift_down) begin
      idx_q <= idx_q + AW'(1);
    end
    if (cmd_i.shift_up || cmd_i.shift_down) begin
      wr_addr_q <= idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pend_q <= 1'b0;
    end else begin
      wr_pend_q <= cmd_i.shift_up || cmd_i.shift_down;
    end
  end

  // Entry memory: one write and one registered read a cycle.
  logic [ENTRY_WIDTH-1:0] mem [CAPACITY];
  logic [ENTRY_WIDTH-1:0] rd_q, wr_data;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic                   rd_en, wr_en;
  logic [63:0]            word_wide, rd_wide;

  assign word_wide = 64'(word_q);
  assign rd_wide   = 64'(rd_q);

  always_comb begin
    rd_en   = cmd_i.rd_tgt || cmd_i.shift_up || cmd_i.shift_down;
    rd_addr = tgt;
    if (cmd_i.shift_up) rd_addr = idx_q - AW'(1);
    else if (cmd_i.shift_down) rd_addr = idx_q + AW'(1);
    wr_en   = cmd_i.put || wr_pend_q;
    wr_addr = cmd_i.put ? tgt : wr_addr_q;
    wr_data = cmd_i.put ? word_wide[ENTRY_WIDTH-1:0] : rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Length update at the end of a request.
  always_comb begin
    count_d = count_q;
    if (st == ST_OK) begin
      case (op)
        OP_INSERT: count_d = count_q + CW'(1);
        OP_DELETE: count_d = count_q - CW'(1);
        OP_CLEAR:  count_d = '0;
        default:   count_d = count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.finish) begin
      count_q <= count_d;
    end
  end

  // Result register; a new result may load as the old one is taken.
  logic out_valid_q;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_word_o   <= (op == OP_READ && st == ST_OK) ? rd_wide[WordW-1:0] : '0;
      out_len_o    <= LenW'(count_d);
      out_status_o <= st;
    end
  end

  assign out_valid_o = out_valid_q;

  // Status to the controller.
  assign sts_o.op        = op;
  assign sts_o.ok        = (st == ST_OK);
  assign sts_o.up_done   = (idx_q == tgt);
  assign sts_o.down_done = (idx_x + 9'd1 >= cnt_x);
  assign sts_o.out_free  = out_free;

`ifndef SYNTHESIS
  // The length never passes the capacity.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("list length above capacity");

  // The final write of an insert never collides with a shift write.
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.put && wr_pend_q))
    else $error("two writes to the entry memory in one cycle");

  // The length changes only when a request finishes.
  a_count_at_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |-> $past(cmd_i.finish))
    else $error("length changed outside request completion");

  // An insert rejected as full leaves the length as it was.
  a_full_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && st == ST_FULL |=> count_q == $past(count_q))
    else $error("full list changed length");
`endif

endmodule
